[rtl/ifls_pkg.sv]
// ----------------------------------------------------------------------------
// ifls_pkg
// Shared codes and types for the index free-list store: request opcodes,
// result status codes, controller states and the command bundle.
// ----------------------------------------------------------------------------
package ifls_pkg;

    // request opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_GET    = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // nine-bit signed "none" value
    localparam logic [8:0] LINK_NONE = 9'h1FF;

    // controller states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } ifls_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;  // latch request, launch table read
        logic commit;   // apply update, load result register
    } ifls_cmd_t;

endpackage

[rtl/ifls_ctrl.sv]
// ----------------------------------------------------------------------------
// ifls_ctrl
// Request sequencer: takes a request in idle, waits in exec for the table
// read, then commits once the result register is free.
// ----------------------------------------------------------------------------
module ifls_ctrl
    import ifls_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      res_valid,
    input  logic      res_ready,
    output ifls_cmd_t cmd
);

    ifls_state_t state_reg;
    ifls_state_t state_next;
    logic        res_valid_reg;
    logic        res_valid_next;

    // handshake and commands
    always_comb
    begin
        req_ready   = (state_reg == ST_IDLE);
        cmd.capture = req_valid && req_ready;
        cmd.commit  = (state_reg == ST_EXEC) && (!res_valid_reg || res_ready);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.commit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

[rtl/ifls_dp.sv]
// ----------------------------------------------------------------------------
// ifls_dp
// Datapath: record tables, free-list head, high-water count, request
// capture and result register.
// ----------------------------------------------------------------------------
module ifls_dp
    import ifls_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ifls_cmd_t          cmd,
    input  logic        [1:0]  op,
    input  logic        [31:0] elem_id,
    input  logic        [31:0] pos_x,
    input  logic        [31:0] pos_y,
    input  logic signed [8:0]  link_in,
    input  logic signed [8:0]  slot,
    output logic        [1:0]  status,
    output logic signed [8:0]  slot_out,
    output logic        [31:0] elem_id_out,
    output logic        [31:0] pos_x_out,
    output logic        [31:0] pos_y_out,
    output logic signed [8:0]  link_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // record tables
    logic [31:0] id_mem   [CAPACITY];
    logic [31:0] x_mem    [CAPACITY];
    logic [31:0] y_mem    [CAPACITY];
    logic [8:0]  link_mem [CAPACITY];

    // list state
    logic [8:0]    free_head_reg;
    logic [8:0]    free_head_next;
    logic [CW-1:0] used_count_reg;
    logic [CW-1:0] used_count_next;

    // captured request
    logic [1:0]  op_reg;
    logic [31:0] elem_id_reg;
    logic [31:0] pos_x_reg;
    logic [31:0] pos_y_reg;
    logic [8:0]  link_in_reg;
    logic [8:0]  slot_reg;

    // table read data
    logic [31:0] id_rd_reg;
    logic [31:0] x_rd_reg;
    logic [31:0] y_rd_reg;
    logic [8:0]  link_rd_reg;

    // result register
    logic [1:0]  status_reg;
    logic [8:0]  slot_out_reg;
    logic [31:0] elem_id_out_reg;
    logic [31:0] pos_x_out_reg;
    logic [31:0] pos_y_out_reg;
    logic [8:0]  link_out_reg;

    // read address selection
    logic [1:0]    rd_op;
    logic [8:0]    rd_slot;
    logic [AW-1:0] head_idx;
    logic [AW-1:0] rd_slot_idx;
    logic [AW-1:0] rd_link_idx;

    // execute signals
    logic          head_ok;
    logic          slot_ok;
    logic [AW-1:0] slot_idx;
    logic [AW-1:0] wr_idx;
    logic          rec_wr;
    logic          link_wr;
    logic [8:0]    link_wr_data;
    logic [1:0]    status_next;
    logic [8:0]    slot_out_next;
    logic [31:0]   elem_id_out_next;
    logic [31:0]   pos_x_out_next;
    logic [31:0]   pos_y_out_next;
    logic [8:0]    link_out_next;

    // read address: live request on capture, held request afterwards
    always_comb
    begin
        rd_op       = cmd.capture ? op : op_reg;
        rd_slot     = cmd.capture ? slot : slot_reg;
        head_idx    = AW'(free_head_reg[7:0]);
        rd_slot_idx = AW'(rd_slot[7:0]);
        rd_link_idx = (rd_op == OP_INSERT) ? head_idx : rd_slot_idx;
    end

    // range checks
    always_comb
    begin
        head_ok  = !free_head_reg[8] && (32'(free_head_reg[7:0]) < 32'(CAPACITY));
        slot_ok  = !slot_reg[8] && (32'(slot_reg[7:0]) < 32'(used_count_reg));
        slot_idx = AW'(slot_reg[7:0]);
    end

    // execute: decide update and result
    always_comb
    begin
        free_head_next   = free_head_reg;
        used_count_next  = used_count_reg;
        wr_idx           = slot_idx;
        rec_wr           = 1'b0;
        link_wr          = 1'b0;
        link_wr_data     = link_in_reg;
        status_next      = STATUS_OK;
        slot_out_next    = LINK_NONE;
        elem_id_out_next = '0;
        pos_x_out_next   = '0;
        pos_y_out_next   = '0;
        link_out_next    = '0;
        case (op_reg)
            OP_INSERT:
            begin
                if (head_ok)
                begin
                    wr_idx         = head_idx;
                    free_head_next = link_rd_reg;
                    rec_wr         = 1'b1;
                    link_wr        = 1'b1;
                    slot_out_next  = 9'(head_idx);
                end
                else if (32'(used_count_reg) < 32'(CAPACITY))
                begin
                    wr_idx          = AW'(used_count_reg);
                    used_count_next = used_count_reg + CW'(1);
                    rec_wr          = 1'b1;
                    link_wr         = 1'b1;
                    slot_out_next   = 9'(used_count_reg);
                end
                else
                begin
                    status_next = STATUS_FULL;
                end
            end
            OP_REMOVE:
            begin
                if (slot_ok)
                begin
                    link_wr        = 1'b1;
                    link_wr_data   = free_head_reg;
                    free_head_next = slot_reg;
                end
                else
                begin
                    status_next = STATUS_RANGE;
                end
            end
            OP_GET:
            begin
                if (slot_ok)
                begin
                    elem_id_out_next = id_rd_reg;
                    pos_x_out_next   = x_rd_reg;
                    pos_y_out_next   = y_rd_reg;
                    link_out_next    = link_rd_reg;
                end
                else
                begin
                    status_next = STATUS_RANGE;
                end
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    // record tables, registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.commit && rec_wr)
        begin
            id_mem[wr_idx] <= elem_id_reg;
            x_mem[wr_idx]  <= pos_x_reg;
            y_mem[wr_idx]  <= pos_y_reg;
        end
        id_rd_reg <= id_mem[rd_slot_idx];
        x_rd_reg  <= x_mem[rd_slot_idx];
        y_rd_reg  <= y_mem[rd_slot_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && link_wr)
        begin
            link_mem[wr_idx] <= link_wr_data;
        end
        link_rd_reg <= link_mem[rd_link_idx];
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= op;
            elem_id_reg <= elem_id;
            pos_x_reg   <= pos_x;
            pos_y_reg   <= pos_y;
            link_in_reg <= link_in;
            slot_reg    <= slot;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg      <= status_next;
            slot_out_reg    <= slot_out_next;
            elem_id_out_reg <= elem_id_out_next;
            pos_x_out_reg   <= pos_x_out_next;
            pos_y_out_reg   <= pos_y_out_next;
            link_out_reg    <= link_out_next;
        end
    end

    // list state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg  <= LINK_NONE;
            used_count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            free_head_reg  <= free_head_next;
            used_count_reg <= used_count_next;
        end
    end

    assign status      = status_reg;
    assign slot_out    = slot_out_reg;
    assign elem_id_out = elem_id_out_reg;
    assign pos_x_out   = pos_x_out_reg;
    assign pos_y_out   = pos_y_out_reg;
    assign link_out    = link_out_reg;

`ifndef ASSERT_OFF
    // high-water count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_count_reg) <= 32'(CAPACITY))
        else $error("used count beyond capacity");

    // high-water count grows by at most one per cycle and never shrinks
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (used_count_reg == $past(used_count_reg)) ||
                 (used_count_reg == $past(used_count_reg) + CW'(1)))
        else $error("used count moved by more than one");

    // list head only moves on a commit
    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(free_head_reg))
        else $error("free head changed without commit");

    // a good remove makes the removed slot the new head
    a_remove_push: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && (op_reg == OP_REMOVE) && slot_ok |=>
            free_head_reg == $past(slot_reg))
        else $error("remove did not push slot");
`endif

endmodule

[rtl/index_free_list_store.sv]
// ----------------------------------------------------------------------------
// index_free_list_store
// Fixed table of element records with slot reuse through a free list.
//
// Usage:
// - request channel (req_valid/req_ready) carries op, elem_id, pos_x, pos_y,
//   link_in and slot; insert, remove or get, one result per request
// - result channel (res_valid/res_ready) carries status, slot_out and the
//   record fields read by get
// - each request first reads the link table (free head for insert, the
//   slot for remove and get) and the record tables, then updates and loads
//   the result register; the next request is taken in the cycle after that,
//   so a new request is not accepted while one is still in flight
// - result valid is registered from the commit, so it rises after the
//   update once the result register is free
// - a stalled result holds; a request already taken waits in its update
//   cycle until the result register frees, then commits
// - reset empties the free list and clears the high-water count; table
//   contents are undefined until written and need no clearing pass
// ----------------------------------------------------------------------------
module index_free_list_store
    import ifls_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic        [1:0]  op,
    input  logic        [31:0] elem_id,
    input  logic        [31:0] pos_x,
    input  logic        [31:0] pos_y,
    input  logic signed [8:0]  link_in,
    input  logic signed [8:0]  slot,
    output logic               res_valid,
    input  logic               res_ready,
    output logic        [1:0]  status,
    output logic signed [8:0]  slot_out,
    output logic        [31:0] elem_id_out,
    output logic        [31:0] pos_x_out,
    output logic        [31:0] pos_y_out,
    output logic signed [8:0]  link_out
);

    ifls_cmd_t cmd;

    // sequencer
    ifls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .cmd       (cmd)
    );

    // tables and list state
    ifls_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .op          (op),
        .elem_id     (elem_id),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .link_in     (link_in),
        .slot        (slot),
        .status      (status),
        .slot_out    (slot_out),
        .elem_id_out (elem_id_out),
        .pos_x_out   (pos_x_out),
        .pos_y_out   (pos_y_out),
        .link_out    (link_out)
    );

endmodule
